/* hdl/buffer_descriptor_table_core_assert.svh */
// Assertion macros used by the descriptor table core.
`ifndef BUFFER_DESCRIPTOR_TABLE_CORE_ASSERT_SVH
`define BUFFER_DESCRIPTOR_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is held.
`define BDT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is held.
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BDT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/bdt_pkg.sv */
package bdt_pkg;

    // Field widths of the stream payload
    localparam int FIELD_W = 48;
    localparam int ADDR_BITS = 48;
    // Bits of an address or size that are kept and stored
    localparam int KEEP_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int AGE_W = 32;

    localparam int DEF_CAPACITY = 64;

    // Request kinds
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    // One stored descriptor
    typedef struct packed {
        logic              valid;
        logic [KEEP_W-1:0] start;
        logic [KEEP_W-1:0] size;
        logic [KEEP_W-1:0] page;
        logic [AGE_W-1:0]  age;
    } t_entry;

    // Outcome of a scan over the table
    typedef struct packed {
        logic              found;
        logic              free_found;
        logic [KEEP_W-1:0] size;
        logic [KEEP_W-1:0] page;
    } t_pick;

endpackage

/* hdl/bdt_ram.sv */
module bdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/bdt_select.sv */
module bdt_select #(
    parameter int CAPACITY = bdt_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_dv,
    input  logic [$clog2(CAPACITY)-1:0]  i_idx,
    input  bdt_pkg::t_entry              i_entry,
    input  logic [bdt_pkg::KEEP_W-1:0]   i_key,
    input  logic [bdt_pkg::AGE_W-1:0]    i_counter,
    output bdt_pkg::t_pick               o_pick,
    output logic [$clog2(CAPACITY)-1:0]  o_best_idx,
    output logic [$clog2(CAPACITY)-1:0]  o_free_idx
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                        r_found;
    logic                        r_free_found;
    logic [IDX_W-1:0]            r_best_idx;
    logic [IDX_W-1:0]            r_free_idx;
    logic [bdt_pkg::KEEP_W-1:0]  r_size;
    logic [bdt_pkg::KEEP_W-1:0]  r_page;
    logic [bdt_pkg::AGE_W-1:0]   r_dist;

    logic                        w_match;
    logic                        w_better;
    logic [bdt_pkg::AGE_W-1:0]   w_dist;

    // Rank the entry: smallest size first, then most recent insert
    always_comb begin
        w_match  = i_entry.valid && (i_entry.start == i_key);
        w_dist   = i_counter - i_entry.age;
        w_better = !r_found || (i_entry.size < r_size) ||
                   ((i_entry.size == r_size) && (w_dist < r_dist));
    end

    // Track the best match and the lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_dv) begin
            if (w_match && w_better) begin
                r_found    <= 1'b1;
                r_best_idx <= i_idx;
                r_size     <= i_entry.size;
                r_page     <= i_entry.page;
                r_dist     <= w_dist;
            end
            if (!i_entry.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_idx;
            end
        end
    end

    assign o_pick.found      = r_found;
    assign o_pick.free_found = r_free_found;
    assign o_pick.size       = r_size;
    assign o_pick.page       = r_page;
    assign o_best_idx        = r_best_idx;
    assign o_free_idx        = r_free_idx;

endmodule

/* hdl/buffer_descriptor_table_core.sv */
// Each request reads every entry of the descriptor memory once, one entry per cycle through
// its single read port; an insert with a zero address or size skips this scan and goes
// straight to commit. No new request is taken until the current one is committed; a result
// may wait at the output while the next request is taken.
// Reset (synchronous, active low) starts a clearing pass over every entry of the memory,
// during which no request is taken.
`include "buffer_descriptor_table_core_assert.svh"

module buffer_descriptor_table_core #(
    parameter int CAPACITY = bdt_pkg::DEF_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [47:0] start_address, [95:48] byte_count, [143:96] page_address
    input  logic [143:0] i_s_tdata,
    // [0] op
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [47:0] removed_size, [95:48] removed_page
    output logic [95:0]  o_m_tdata,
    // [1:0] status
    output logic [1:0]   o_m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int KW = bdt_pkg::KEEP_W;
    localparam int FW = bdt_pkg::FIELD_W;
    localparam int EW = $bits(bdt_pkg::t_entry);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } t_state;

    t_state                      r_state;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_dv;
    logic [IDX_W-1:0]            r_dv_idx;
    logic                        r_op;
    logic                        r_bad;
    logic [KW-1:0]               r_key;
    logic [KW-1:0]               r_size;
    logic [KW-1:0]               r_page;
    logic [bdt_pkg::AGE_W-1:0]   r_counter;
    logic                        r_out_vld;
    bdt_pkg::t_status            r_out_status;
    logic [FW-1:0]               r_out_size;
    logic [FW-1:0]               r_out_page;

    logic                        w_accept;
    logic                        w_fire;
    logic                        w_last_idx;
    logic [KW-1:0]               w_in_key;
    logic [KW-1:0]               w_in_size;
    logic [KW-1:0]               w_in_page;
    logic                        w_wr_en;
    logic [IDX_W-1:0]            w_wr_addr;
    bdt_pkg::t_entry             w_wr_entry;
    logic [EW-1:0]               w_rd_data;
    bdt_pkg::t_entry             w_rd_entry;
    bdt_pkg::t_pick              w_pick;
    logic [IDX_W-1:0]            w_best_idx;
    logic [IDX_W-1:0]            w_free_idx;
    bdt_pkg::t_status            w_status;
    logic                        w_store;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = (r_state == ST_COMMIT) && (!r_out_vld || i_m_tready);
    assign w_last_idx = (r_idx == IDX_W'(CAPACITY - 1));
    assign w_in_key   = i_s_tdata[KW-1:0];
    assign w_in_size  = i_s_tdata[FW+KW-1:FW];
    assign w_in_page  = i_s_tdata[2*FW+KW-1:2*FW];
    assign w_rd_entry = bdt_pkg::t_entry'(w_rd_data);

    // Decide the outcome of the request at commit
    always_comb begin
        w_status = bdt_pkg::STAT_OK;
        w_store  = 1'b0;
        if (r_op == bdt_pkg::OP_INSERT) begin
            if (r_bad) begin
                w_status = bdt_pkg::STAT_INVALID;
            end else if (!w_pick.free_found) begin
                w_status = bdt_pkg::STAT_FULL;
            end else begin
                w_store = 1'b1;
            end
        end else begin
            if (!w_pick.found) begin
                w_status = bdt_pkg::STAT_NOT_FOUND;
            end
        end
    end

    // Memory write: clearing pass, new descriptor, or release of the removed one
    always_comb begin
        w_wr_entry = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_idx;
        if (r_state == ST_CLEAR) begin
            w_wr_en = 1'b1;
        end else if (w_fire) begin
            if (r_op == bdt_pkg::OP_INSERT) begin
                w_wr_en          = w_store;
                w_wr_addr        = w_free_idx;
                w_wr_entry.valid = 1'b1;
                w_wr_entry.start = r_key;
                w_wr_entry.size  = r_size;
                w_wr_entry.page  = r_page;
                w_wr_entry.age   = r_counter;
            end else begin
                w_wr_en   = w_pick.found;
                w_wr_addr = w_best_idx;
            end
        end
    end

    bdt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (EW'(w_wr_entry)),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    bdt_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dv       (r_dv),
        .i_idx      (r_dv_idx),
        .i_entry    (w_rd_entry),
        .i_key      (r_key),
        .i_counter  (r_counter),
        .o_pick     (w_pick),
        .o_best_idx (w_best_idx),
        .o_free_idx (w_free_idx)
    );

    // Sequencer: clear, wait for a request, scan, commit and present the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_counter <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_dv     <= (r_state == ST_SCAN);
            r_dv_idx <= r_idx;
            // Present a new result, or drop the one just taken
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_idx <= w_last_idx ? '0 : r_idx + 1'b1;
                    if (w_last_idx) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_s_tuser[0];
                        r_key  <= w_in_key;
                        r_size <= w_in_size;
                        r_page <= w_in_page;
                        r_bad  <= (w_in_key == '0) || (w_in_size == '0);
                        r_idx  <= '0;
                        if ((i_s_tuser[0] == bdt_pkg::OP_INSERT) &&
                            ((w_in_key == '0) || (w_in_size == '0))) begin
                            r_state <= ST_COMMIT;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_idx <= w_last_idx ? '0 : r_idx + 1'b1;
                    if (w_last_idx) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (w_fire) begin
                        r_out_status <= w_status;
                        if ((r_op == bdt_pkg::OP_REMOVE) && w_pick.found) begin
                            r_out_size <= FW'(w_pick.size);
                            r_out_page <= FW'(w_pick.page);
                        end else begin
                            r_out_size <= '0;
                            r_out_page <= '0;
                        end
                        if (w_store) begin
                            r_counter <= r_counter + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_page, r_out_size};
    assign o_m_tuser  = r_out_status;

    // The memory is written only by the clearing pass or at commit
    `BDT_ASSERT_IMPLIES(a_wr_phase, i_clk, i_rst_n, w_wr_en, (r_state == ST_CLEAR) || (r_state == ST_COMMIT))
    // A taken request blocks the next one
    `BDT_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, w_accept, !o_s_tready)
    // Read data is consumed only right after a scan read
    `BDT_ASSERT_IMPLIES(a_dv_after_scan, i_clk, i_rst_n, r_dv, $past(r_state == ST_SCAN))
    // A failed lookup returns no descriptor
    `BDT_ASSERT_IMPLIES(a_not_found_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == bdt_pkg::STAT_NOT_FOUND), o_m_tdata == '0)

endmodule

/* bench/buffer_descriptor_table_core_test.sv */
`timescale 1ns / 100ps

module buffer_descriptor_table_core_test;

    localparam int SLOTS = bdt_pkg::DEF_CAPACITY;
    localparam int FW = bdt_pkg::FIELD_W;
    localparam int AW = bdt_pkg::AGE_W;
    localparam int DIRECTED_ITEMS = 18;
    localparam int RANDOM_ITEMS = 1850 - DIRECTED_ITEMS;
    localparam int POOL_N = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [FW-1:0] KEEP_MASK = ~({FW{1'b1}} << bdt_pkg::KEEP_W);
    localparam logic [FW-1:0] ALL_ONES = {FW{1'b1}};

    // One result of the block: status plus the removed descriptor
    typedef struct packed {
        bdt_pkg::t_status status;
        logic [FW-1:0]    size;
        logic [FW-1:0]    page;
    } t_result;

    // Mirror of the descriptor store and the queue of results it predicts
    class descriptor_tracker;
        bit            used[SLOTS];
        logic [FW-1:0] start_of[SLOTS];
        logic [FW-1:0] size_of[SLOTS];
        logic [FW-1:0] page_of[SLOTS];
        logic [AW-1:0] age_of[SLOTS];
        logic [AW-1:0] insert_count;
        t_result       pending_results[$];
        int            mismatches;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            insert_count = '0;
            mismatches = 0;
        endfunction

        // Apply one accepted request to the mirror and queue its result
        function void note_request(logic op, logic [FW-1:0] addr_in,
                                   logic [FW-1:0] size_in, logic [FW-1:0] page_in);
            t_result       r;
            logic [FW-1:0] addr;
            logic [FW-1:0] size;
            logic [FW-1:0] page;
            logic [AW-1:0] age_gap;
            logic [AW-1:0] best_gap;
            int            slot;
            int            best;
            addr = addr_in & KEEP_MASK;
            size = size_in & KEEP_MASK;
            page = page_in & KEEP_MASK;
            r.status = bdt_pkg::STAT_OK;
            r.size = '0;
            r.page = '0;
            if (op == bdt_pkg::OP_INSERT) begin
                if (addr == '0 || size == '0) begin
                    r.status = bdt_pkg::STAT_INVALID;
                end else begin
                    slot = -1;
                    for (int i = 0; i < SLOTS && slot < 0; i++) begin
                        if (!used[i]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = bdt_pkg::STAT_FULL;
                    end else begin
                        used[slot] = 1'b1;
                        start_of[slot] = addr;
                        size_of[slot] = size;
                        page_of[slot] = page;
                        age_of[slot] = insert_count;
                        insert_count = insert_count + 1'b1;
                    end
                end
            end else begin
                // smallest size wins, then the shortest distance back to its insert
                best = -1;
                best_gap = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (used[i] && start_of[i] == addr) begin
                        age_gap = insert_count - age_of[i];
                        if (best < 0 || size_of[i] < size_of[best] ||
                            (size_of[i] == size_of[best] && age_gap < best_gap)) begin
                            best = i;
                            best_gap = age_gap;
                        end
                    end
                end
                if (best < 0) begin
                    r.status = bdt_pkg::STAT_NOT_FOUND;
                end else begin
                    used[best] = 1'b0;
                    r.size = size_of[best];
                    r.page = page_of[best];
                end
            end
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(bdt_pkg::t_status status, logic [FW-1:0] size,
                                   logic [FW-1:0] page);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: status %0d size %h page %h",
                       status, size, page);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (size !== want.size) begin
                $error("removed_size: expected %h, got %h", want.size, size);
                mismatches++;
            end
            if (page !== want.page) begin
                $error("removed_page: expected %h, got %h", want.page, page);
                mismatches++;
            end
        endfunction

        // Return the start address of a random stored descriptor, if any
        function bit pick_stored(output logic [FW-1:0] addr);
            int count;
            int k;
            count = 0;
            addr = '0;
            foreach (used[i]) if (used[i]) count++;
            if (count == 0) return 1'b0;
            k = $urandom_range(count - 1);
            foreach (used[i]) begin
                if (used[i]) begin
                    if (k == 0) addr = start_of[i];
                    k--;
                end
            end
            return 1'b1;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // [47:0] start_address, [95:48] byte_count, [143:96] page_address
    logic [143:0] i_s_tdata;
    // [0] op
    logic [0:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // [47:0] removed_size, [95:48] removed_page
    logic [95:0]  o_m_tdata;
    // [1:0] status
    logic [1:0]   o_m_tuser;

    descriptor_tracker tracker;
    logic [FW-1:0] addr_pool[POOL_N];
    logic hold_off = 1'b0;
    logic calm = 1'b0;
    int   sent_count = 0;
    int   stall_left = 0;
    int   cycle_count = 0;

    buffer_descriptor_table_core #(
        .CAPACITY(SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("buffer_descriptor_table_core_test: FAIL");
            $finish;
        end
    end

    // Check results, then drive the ready of the result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_result(bdt_pkg::t_status'(o_m_tuser), o_m_tdata[47:0],
                                 o_m_tdata[95:48]);
        end
        if (!i_rst_n || hold_off) begin
            i_m_tready <= 1'b0;
        end else if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(1999) == 0) begin
            stall_left <= $urandom_range(150, 20);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 10);
        end
    end

    // Hold off the result side long enough to back up the request side
    initial begin
        wait (sent_count >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic logic [FW-1:0] rand48();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] rand_addr();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 70) return addr_pool[$urandom_range(POOL_N - 1)];
        return rand48();
    endfunction

    function automatic logic [FW-1:0] rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 34) return FW'($urandom_range(4, 1));
        if (r < 42) return ALL_ONES;
        return rand48() >> $urandom_range(FW - 1);
    endfunction

    function automatic logic [FW-1:0] rand_page();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return ALL_ONES;
        return rand48();
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic op, input logic [FW-1:0] addr,
                                input logic [FW-1:0] size,
                                input logic [FW-1:0] page);
        if (!calm && !hold_off && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(120, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {page, size, addr};
        i_s_tuser <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker.note_request(op, addr, size, page);
        sent_count++;
    endtask

    initial begin
        logic [FW-1:0] addr;
        logic [FW-1:0] a_dir;
        logic [FW-1:0] size;
        logic          op;
        int            insert_pct;
        tracker = new();
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= '0;
        i_m_tready <= 1'b0;
        addr_pool[0] = ALL_ONES;
        addr_pool[1] = FW'(1);
        for (int i = 2; i < POOL_N; i++) begin
            addr_pool[i] = rand48();
            if (addr_pool[i] == '0) addr_pool[i] = FW'(2);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: invalid inserts, misses on an empty store, extremes, size ties
        a_dir = 48'h0000_1234_5678;
        send_request(bdt_pkg::OP_INSERT, '0, 48'h5, 48'h1000);
        send_request(bdt_pkg::OP_INSERT, a_dir, '0, 48'h2000);
        send_request(bdt_pkg::OP_INSERT, '0, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, '0, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, ALL_ONES, '0, '0);
        send_request(bdt_pkg::OP_INSERT, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(bdt_pkg::OP_INSERT, a_dir, 48'h100, 48'hAAAA_0001_0000);
        send_request(bdt_pkg::OP_INSERT, a_dir, 48'h80, 48'hAAAA_0002_0000);
        send_request(bdt_pkg::OP_INSERT, a_dir, 48'h80, 48'hAAAA_0003_0000);
        send_request(bdt_pkg::OP_INSERT, a_dir, 48'h200, 48'hAAAA_0004_0000);
        send_request(bdt_pkg::OP_REMOVE, a_dir, ALL_ONES, ALL_ONES);
        send_request(bdt_pkg::OP_REMOVE, a_dir, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, a_dir, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, a_dir, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, a_dir, '0, '0);
        send_request(bdt_pkg::OP_REMOVE, ALL_ONES, '0, '0);
        send_request(bdt_pkg::OP_INSERT, FW'(1), FW'(1), '0);
        send_request(bdt_pkg::OP_REMOVE, FW'(1), ALL_ONES, '0);

        // Random: blocks with their own insert mix, the first one fills the store
        insert_pct = 100;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0 && n != 0) begin
                case ($urandom_range(4))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    2: insert_pct = 65;
                    3: insert_pct = 85;
                    default: insert_pct = 95;
                endcase
            end
            calm <= (n >= 900 && n < 1200);
            op = ($urandom_range(99) < insert_pct) ? bdt_pkg::OP_INSERT : bdt_pkg::OP_REMOVE;
            if (op == bdt_pkg::OP_REMOVE && $urandom_range(99) < 70) begin
                if (!tracker.pick_stored(addr)) addr = rand_addr();
            end else begin
                addr = rand_addr();
            end
            size = rand_size();
            send_request(op, addr, size, rand_page());
        end
        i_s_tvalid <= 1'b0;

        // Drain the outstanding results, then leave room for a stray one
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("buffer_descriptor_table_core_test: PASS");
        end else begin
            $display("buffer_descriptor_table_core_test: FAIL");
        end
        $finish;
    end

endmodule
